// File: rtl/rsi_pkg.sv
package rsi_pkg;

	localparam int MAX_WINDOW_DEF  = 64;
	localparam int PRICE_WIDTH_DEF = 32;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 24;
	localparam int ADDR_W     = 4;
	localparam int APB_DATA_W = 32;

	localparam int WINDOW_W = 7;
	localparam int LEVEL_W  = 14;
	localparam int RSI_W    = 14;

	localparam logic [RSI_W-1:0] RSI_SCALE = 14'd10000;

	localparam logic [WINDOW_W-1:0] WINDOW_RST     = 7'd14;
	localparam logic [LEVEL_W-1:0]  OVERBOUGHT_RST = 14'd7000;
	localparam logic [LEVEL_W-1:0]  OVERSOLD_RST   = 14'd3000;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		REG_WINDOW     = 2'd0,
		REG_OVERBOUGHT = 2'd1,
		REG_OVERSOLD   = 2'd2,
		REG_NONE       = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [WINDOW_W-1:0] window_length;
		logic [LEVEL_W-1:0]  overbought_level;
		logic [LEVEL_W-1:0]  oversold_level;
	} cfg_t;

endpackage

// File: rtl/rsi_queue.sv
module rsi_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int DEPTH = rsi_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/rsi_front.sv
module rsi_front #(
	parameter int MAX_WINDOW  = rsi_pkg::MAX_WINDOW_DEF,
	parameter int PRICE_WIDTH = rsi_pkg::PRICE_WIDTH_DEF,
	parameter int SUM_W       = PRICE_WIDTH + $clog2(MAX_WINDOW)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic [rsi_pkg::WINDOW_W-1:0]  window_length,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rsi_pkg::IN_DATA_W-1:0] in_price,
	output logic                          push_valid,
	input  logic                          push_ready,
	output logic [SUM_W-1:0]              push_gain,
	output logic [SUM_W-1:0]              push_loss,
	output logic                          push_full
);

	localparam int CNT_W = $clog2(MAX_WINDOW + 2);
	localparam int PTR_W = $clog2(MAX_WINDOW);

	typedef enum logic {
		F_IDLE,
		F_UPDATE
	} front_state_t;

	front_state_t           state_q;
	logic [PRICE_WIDTH:0]   change_ring_q [MAX_WINDOW];
	logic [PRICE_WIDTH:0]   old_q;
	logic [PRICE_WIDTH-1:0] price_q;
	logic [PRICE_WIDTH-1:0] prev_q;
	logic [SUM_W-1:0]       gain_q;
	logic [SUM_W-1:0]       loss_q;
	logic [CNT_W-1:0]       seen_q;
	logic [PTR_W-1:0]       ptr_q;

	logic [CNT_W-1:0]       eff_len;
	logic [CNT_W-1:0]       len_p1;
	logic [PTR_W-1:0]       slot;
	logic [CNT_W-1:0]       slot_inc;
	logic [PTR_W-1:0]       ptr_nx;
	logic                   have_prev;
	logic                   full_win;
	logic                   rise;
	logic [PRICE_WIDTH-1:0] mag;
	logic [PRICE_WIDTH:0]   entry;
	logic [SUM_W-1:0]       gain_add;
	logic [SUM_W-1:0]       gain_sub;
	logic [SUM_W-1:0]       loss_add;
	logic [SUM_W-1:0]       loss_sub;
	logic [SUM_W-1:0]       gain_nx;
	logic [SUM_W-1:0]       loss_nx;
	logic [CNT_W-1:0]       seen_nx;
	logic                   accept;
	logic                   commit;

	always_comb begin
		if (window_length == '0) begin
			eff_len = CNT_W'(1);
		end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
			eff_len = CNT_W'(MAX_WINDOW);
		end else begin
			eff_len = CNT_W'(window_length);
		end
	end

	assign len_p1    = eff_len + CNT_W'(1);
	assign slot      = (CNT_W'(ptr_q) >= eff_len) ? '0 : ptr_q;
	assign slot_inc  = CNT_W'(slot) + CNT_W'(1);
	assign ptr_nx    = (slot_inc >= eff_len) ? '0 : PTR_W'(slot_inc);
	assign have_prev = (seen_q != '0);
	assign full_win  = (seen_q >= len_p1);

	assign rise  = (price_q >= prev_q);
	assign mag   = rise ? (price_q - prev_q) : (prev_q - price_q);
	assign entry = {!rise, mag};

	// Retire the oldest change once the window is full, then add the new one.
	assign gain_add = (have_prev && rise) ? SUM_W'(mag) : '0;
	assign loss_add = (have_prev && !rise) ? SUM_W'(mag) : '0;
	assign gain_sub = (have_prev && full_win && !old_q[PRICE_WIDTH]) ?
		SUM_W'(old_q[PRICE_WIDTH-1:0]) : '0;
	assign loss_sub = (have_prev && full_win && old_q[PRICE_WIDTH]) ?
		SUM_W'(old_q[PRICE_WIDTH-1:0]) : '0;
	assign gain_nx  = gain_q + gain_add - gain_sub;
	assign loss_nx  = loss_q + loss_add - loss_sub;
	assign seen_nx  = (seen_q < len_p1) ? seen_q + CNT_W'(1) : seen_q;

	assign in_ready   = (state_q == F_IDLE);
	assign push_valid = (state_q == F_UPDATE);
	assign push_gain  = gain_nx;
	assign push_loss  = loss_nx;
	assign push_full  = (seen_nx >= len_p1);
	assign accept     = in_valid && in_ready;
	assign commit     = push_valid && push_ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			old_q   <= change_ring_q[slot];
			price_q <= PRICE_WIDTH'(in_price);
		end
		if (commit && have_prev) begin
			change_ring_q[slot] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			prev_q  <= '0;
			gain_q  <= '0;
			loss_q  <= '0;
			seen_q  <= '0;
			ptr_q   <= '0;
		end else if (clear) begin
			state_q <= F_IDLE;
			prev_q  <= '0;
			gain_q  <= '0;
			loss_q  <= '0;
			seen_q  <= '0;
			ptr_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_UPDATE;
					end
				end
				F_UPDATE: begin
					if (commit) begin
						prev_q  <= price_q;
						gain_q  <= gain_nx;
						loss_q  <= loss_nx;
						seen_q  <= seen_nx;
						if (have_prev) begin
							ptr_q <= ptr_nx;
						end
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/rsi_back.sv
module rsi_back #(
	parameter int SUM_W = rsi_pkg::PRICE_WIDTH_DEF + $clog2(rsi_pkg::MAX_WINDOW_DEF)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rsi_pkg::cfg_t                  cfg,
	input  logic                           pop_valid,
	output logic                           pop_ready,
	input  logic [SUM_W-1:0]               pop_gain,
	input  logic [SUM_W-1:0]               pop_loss,
	input  logic                           pop_full,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rsi_pkg::OUT_DATA_W-1:0] out_data
);

	localparam int RSI_W = rsi_pkg::RSI_W;
	localparam int NUM_W = SUM_W + RSI_W;
	localparam int BIT_W = $clog2(RSI_W);

	typedef enum logic [1:0] {
		B_IDLE,
		B_LOAD,
		B_DIV,
		B_OUT
	} back_state_t;

	back_state_t      state_q;
	logic [SUM_W-1:0] gain_q;
	logic [SUM_W-1:0] loss_q;
	logic             full_q;
	logic             no_loss_q;
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] div_q;
	logic [RSI_W-1:0] quo_q;
	logic [BIT_W-1:0] bit_q;
	logic             out_valid_q;
	logic [rsi_pkg::OUT_DATA_W-1:0] out_data_q;

	logic             fits;
	logic             load_out;
	logic [RSI_W-1:0] rsi_val;
	logic             ob_val;
	logic             os_val;

	assign pop_ready = (state_q == B_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign fits      = (rem_q >= div_q);
	assign load_out  = (state_q == B_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		if (!full_q) begin
			rsi_val = '0;
			ob_val  = 1'b0;
			os_val  = 1'b0;
		end else if (no_loss_q) begin
			rsi_val = rsi_pkg::RSI_SCALE;
			ob_val  = 1'b1;
			os_val  = 1'b0;
		end else begin
			rsi_val = quo_q;
			ob_val  = (quo_q >= cfg.overbought_level);
			os_val  = (quo_q <= cfg.oversold_level);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			gain_q      <= '0;
			loss_q      <= '0;
			full_q      <= 1'b0;
			no_loss_q   <= 1'b0;
			rem_q       <= '0;
			div_q       <= '0;
			quo_q       <= '0;
			bit_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_data_q  <= rsi_pkg::OUT_DATA_W'({full_q, os_val, ob_val, rsi_val});
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						gain_q    <= pop_gain;
						loss_q    <= pop_loss;
						full_q    <= pop_full;
						no_loss_q <= (pop_loss == '0);
						state_q   <= B_LOAD;
					end
				end
				B_LOAD: begin
					// Quotient fits in RSI_W bits since gain never exceeds the total.
					rem_q   <= NUM_W'(gain_q) * NUM_W'(rsi_pkg::RSI_SCALE);
					div_q   <= NUM_W'(gain_q + loss_q) << (RSI_W - 1);
					quo_q   <= '0;
					bit_q   <= BIT_W'(RSI_W - 1);
					state_q <= (full_q && !no_loss_q) ? B_DIV : B_OUT;
				end
				B_DIV: begin
					if (fits) begin
						rem_q <= rem_q - div_q;
					end
					quo_q <= {quo_q[RSI_W-2:0], fits};
					div_q <= div_q >> 1;
					bit_q <= bit_q - BIT_W'(1);
					if (bit_q == '0) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/relative_strength_index.sv
// Relative strength index over the last window_length price changes, one result
// item per price item: rsi_hundredths = floor(10000*gain/(gain+loss)), flags from
// the two level registers, all zero until window_length+1 prices have been seen
// (a write of window_length restarts that count). The front end reads the oldest
// change from the ring memory, then updates the running sums, and takes no new
// price until the sums are pushed into a two-item queue. For a valid item with
// nonzero losses the back end pops, multiplies, runs a 14-bit bit-serial division
// and loads the output; otherwise it skips the division. The divider thus sets
// the sustained rate; the queue and output register absorb short bursts.
module relative_strength_index #(
	parameter int MAX_WINDOW  = rsi_pkg::MAX_WINDOW_DEF,
	parameter int PRICE_WIDTH = rsi_pkg::PRICE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [rsi_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] price
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [13:0] rsi_hundredths, [14] overbought, [15] oversold, [16] valid_res
	output logic [rsi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rsi_pkg::ADDR_W-1:0]     paddr,
	input  logic [rsi_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rsi_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);

	localparam int SUM_W = PRICE_WIDTH + $clog2(MAX_WINDOW);
	localparam int Q_W   = 2 * SUM_W + 1;

	rsi_pkg::cfg_t      cfg_q;
	rsi_pkg::reg_index_t reg_sel;
	logic               wr_en;
	logic               clear;

	logic               push_valid;
	logic               push_ready;
	logic [SUM_W-1:0]   push_gain;
	logic [SUM_W-1:0]   push_loss;
	logic               push_full;
	logic               pop_valid;
	logic               pop_ready;
	logic [Q_W-1:0]     pop_data;

	assign pready  = 1'b1;
	assign reg_sel = rsi_pkg::reg_index_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign clear   = wr_en && (reg_sel == rsi_pkg::REG_WINDOW);

	always_comb begin
		unique case (reg_sel)
			rsi_pkg::REG_WINDOW:     prdata = 32'(cfg_q.window_length);
			rsi_pkg::REG_OVERBOUGHT: prdata = 32'(cfg_q.overbought_level);
			rsi_pkg::REG_OVERSOLD:   prdata = 32'(cfg_q.oversold_level);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_length    <= rsi_pkg::WINDOW_RST;
			cfg_q.overbought_level <= rsi_pkg::OVERBOUGHT_RST;
			cfg_q.oversold_level   <= rsi_pkg::OVERSOLD_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				rsi_pkg::REG_WINDOW: begin
					cfg_q.window_length <= pwdata[rsi_pkg::WINDOW_W-1:0];
				end
				rsi_pkg::REG_OVERBOUGHT: begin
					cfg_q.overbought_level <= pwdata[rsi_pkg::LEVEL_W-1:0];
				end
				rsi_pkg::REG_OVERSOLD: begin
					cfg_q.oversold_level <= pwdata[rsi_pkg::LEVEL_W-1:0];
				end
				default: ;
			endcase
		end
	end

	rsi_front #(
		.MAX_WINDOW  (MAX_WINDOW),
		.PRICE_WIDTH (PRICE_WIDTH),
		.SUM_W       (SUM_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.clear         (clear),
		.window_length (cfg_q.window_length),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_price      (s_axis_tdata),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_gain     (push_gain),
		.push_loss     (push_loss),
		.push_full     (push_full)
	);

	rsi_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_full, push_loss, push_gain}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	rsi_back #(
		.SUM_W (SUM_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_gain  (pop_data[SUM_W-1:0]),
		.pop_loss  (pop_data[2*SUM_W-1:SUM_W]),
		.pop_full  (pop_data[Q_W-1]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// File: sim/rsi_checker.sv
module rsi_checker
	import rsi_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic [APB_DATA_W-1:0] prdata,
	input  logic                  pready,
	output int                    errors,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [RSI_W-1:0] rsi;
		logic             overbought;
		logic             oversold;
		logic             valid_res;
	} rsi_result_t;

	logic [WINDOW_W-1:0] window_reg;
	logic [LEVEL_W-1:0]  ob_level;
	logic [LEVEL_W-1:0]  os_level;

	// bit 32 marks a fall, low bits hold the magnitude
	logic [32:0]         change_mem [MAX_WINDOW_DEF];
	logic [31:0]         last_price;
	logic [37:0]         gain_sum;
	logic [37:0]         loss_sum;
	int unsigned         seen;
	int unsigned         slot_ptr;

	rsi_result_t         expected_q [$];
	rsi_result_t         want_item;
	logic [31:0]         reg_want;
	bit                  reg_known;

	initial errors = 0;

	function automatic void restart_history();
		last_price = '0;
		gain_sum   = '0;
		loss_sum   = '0;
		seen       = 0;
		slot_ptr   = 0;
	endfunction

	function automatic rsi_result_t predict_rsi(input logic [31:0] p);
		int unsigned len;
		int unsigned slot;
		logic [32:0] stale;
		logic [63:0] num;
		logic [63:0] den;
		rsi_result_t r;

		if (window_reg == 0)
			len = 1;
		else if (window_reg > MAX_WINDOW_DEF)
			len = MAX_WINDOW_DEF;
		else
			len = 32'(window_reg);

		if (seen > 0) begin
			slot = (slot_ptr >= len) ? 0 : slot_ptr;
			// retire the change that drops out of the window
			if (seen >= len + 1) begin
				stale = change_mem[slot];
				if (stale[32])
					loss_sum -= 38'(stale[31:0]);
				else
					gain_sum -= 38'(stale[31:0]);
			end
			if (p >= last_price) begin
				change_mem[slot] = {1'b0, p - last_price};
				gain_sum += 38'(p - last_price);
			end else begin
				change_mem[slot] = {1'b1, last_price - p};
				loss_sum += 38'(last_price - p);
			end
			slot_ptr = (slot + 1 >= len) ? 0 : slot + 1;
		end
		last_price = p;
		if (seen < len + 1)
			seen++;

		r = '0;
		r.valid_res = (seen >= len + 1);
		if (r.valid_res) begin
			if (loss_sum == 0) begin
				r.rsi        = RSI_SCALE;
				r.overbought = 1'b1;
			end else begin
				num          = 64'(gain_sum) * 64'd10000;
				den          = 64'(gain_sum) + 64'(loss_sum);
				r.rsi        = RSI_W'(num / den);
				r.overbought = (r.rsi >= ob_level);
				r.oversold   = (r.rsi <= os_level);
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("%0t rsi_checker: %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_reg = WINDOW_RST;
			ob_level   = OVERBOUGHT_RST;
			os_level   = OVERSOLD_RST;
			restart_history();
			expected_q.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_index_t'(paddr[3:2]))
						REG_WINDOW: begin
							window_reg = pwdata[WINDOW_W-1:0];
							restart_history();
						end
						REG_OVERBOUGHT: ob_level = pwdata[LEVEL_W-1:0];
						REG_OVERSOLD:   os_level = pwdata[LEVEL_W-1:0];
						default: ;
					endcase
				end else begin
					reg_known = 1'b1;
					case (reg_index_t'(paddr[3:2]))
						REG_WINDOW:     reg_want = 32'(window_reg);
						REG_OVERBOUGHT: reg_want = 32'(ob_level);
						REG_OVERSOLD:   reg_want = 32'(os_level);
						default:        reg_known = 1'b0;
					endcase
					if (reg_known && prdata !== reg_want)
						report_mismatch("register read", prdata, reg_want);
				end
			end

			if (s_axis_tvalid && s_axis_tready)
				expected_q.insert(expected_q.size(), predict_rsi(s_axis_tdata[31:0]));

			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result item with nothing pending", m_axis_tdata, 0);
				end else begin
					want_item = expected_q[0];
					expected_q.delete(0);
					if (m_axis_tdata[13:0] !== want_item.rsi)
						report_mismatch("rsi_hundredths", m_axis_tdata[13:0], want_item.rsi);
					if (m_axis_tdata[14] !== want_item.overbought)
						report_mismatch("overbought", m_axis_tdata[14], want_item.overbought);
					if (m_axis_tdata[15] !== want_item.oversold)
						report_mismatch("oversold", m_axis_tdata[15], want_item.oversold);
					if (m_axis_tdata[16] !== want_item.valid_res)
						report_mismatch("valid_res", m_axis_tdata[16], want_item.valid_res);
					if (m_axis_tdata[OUT_DATA_W-1:17] !== '0)
						report_mismatch("tdata padding", m_axis_tdata[OUT_DATA_W-1:17], 0);
				end
			end

			outstanding <= expected_q.size();
		end
	end

endmodule

// File: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rsi_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int BLOCK_ITEMS    = 100;

	typedef enum {PX_WALK, PX_RISE, PX_FALL, PX_FLAT, PX_EDGES, PX_FULL} price_mode_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  psel          = 1'b0;
	logic                  penable       = 1'b0;
	logic                  pwrite        = 1'b0;
	logic [ADDR_W-1:0]     paddr         = '0;
	logic [APB_DATA_W-1:0] pwdata        = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int errors;
	int outstanding;
	int src_idle     = 25;
	int sink_idle    = 66;
	int quiet_cycles = 0;

	relative_strength_index u_top (.*);

	rsi_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_idle);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic apb_access(input logic write_en, input reg_index_t idx,
			input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write_en;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write with junk above the register width, then read back
	task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
		logic [31:0] mask;
		mask = (idx == REG_WINDOW) ? 32'h7f : 32'h3fff;
		apb_access(1'b1, idx, ($urandom & ~mask) | (value & mask));
		apb_access(1'b0, idx, '0);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic configure(input logic [6:0] window, input logic [13:0] ob,
			input logic [13:0] os);
		wait_drained();
		write_reg(REG_WINDOW, 32'(window));
		write_reg(REG_OVERBOUGHT, 32'(ob));
		write_reg(REG_OVERSOLD, 32'(os));
	endtask

	// hold tvalid across back-to-back items, drop it only for a gap
	task automatic send_price(input logic [31:0] p);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= p;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic logic [31:0] next_price(input price_mode_t m, input logic [31:0] prev);
		longint v;
		if ($urandom_range(19) == 0)
			return $urandom;
		case (m)
			PX_WALK:  v = longint'(prev) + longint'($urandom_range(200)) - 100;
			PX_RISE:  v = longint'(prev) + longint'($urandom_range(50));
			PX_FALL:  v = longint'(prev) - longint'($urandom_range(50));
			PX_FLAT:  v = ($urandom_range(3) == 0) ? longint'(prev) + 1 : longint'(prev);
			PX_EDGES: v = $urandom_range(1) ? 64'd4294967295 : 64'd0;
			default:  v = $urandom;
		endcase
		if (v < 0)
			v = 0;
		else if (v > 64'd4294967295)
			v = 64'd4294967295;
		return v[31:0];
	endfunction

	function automatic logic [13:0] pick_level();
		case ($urandom_range(7))
			0:       return 14'd0;
			1:       return RSI_SCALE;
			2:       return 14'($urandom_range(16383));
			default: return 14'($urandom_range(10000));
		endcase
	endfunction

	task automatic run_prices(input int count, input price_mode_t m, input bit with_pause);
		logic [31:0] p;
		int pause_at;
		p = $urandom_range(1) ? $urandom : 32'($urandom_range(1000));
		pause_at = with_pause ? $urandom_range(count - 1) : -1;
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				wait_drained();
			p = next_price(m, p);
			send_price(p);
		end
	endtask

	logic [31:0]  dir_a [8] = '{100, 100, 100, 100, 200, 0, 32'hffff_ffff, 0};
	logic [31:0]  dir_b [4] = '{10, 5, 20, 20};
	logic [6:0]   widths [6] = '{7'd1, 7'd2, 7'd14, 7'd64, 7'd0, 7'd127};
	price_mode_t  modes [6] = '{PX_WALK, PX_RISE, PX_FALL, PX_FLAT, PX_EDGES, PX_FULL};

	initial begin
		logic [6:0] w;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 3; i++)
			apb_access(1'b0, reg_index_t'(i), '0);

		// reset window of 14: one valid result at the end
		for (int i = 0; i < 15; i++)
			send_price(32'(1000 + ((i % 3 == 0) ? -7 * i : 13 * i)));

		// flat start gives no gains and no losses, then full-scale swings
		configure(7'd3, 14'd7000, 14'd3000);
		foreach (dir_a[i])
			send_price(dir_a[i]);

		// window 0 behaves as 1; levels above the RSI range
		configure(7'd0, 14'd16383, 14'd16383);
		foreach (dir_b[i])
			send_price(dir_b[i]);

		for (int wave = 0; wave < 3; wave++) begin
			case (wave)
				0: begin
					src_idle  = 25;
					sink_idle = 66;
				end
				1: begin
					src_idle  = 66;
					sink_idle = 25;
				end
				default: begin
					src_idle  = 0;
					sink_idle = 0;
				end
			endcase
			for (int sub = 0; sub < 6; sub++) begin
				w = (sub == 5) ? 7'($urandom_range(127)) : widths[(sub + 2 * wave) % 6];
				configure(w, pick_level(), pick_level());
				run_prices(BLOCK_ITEMS, modes[(sub + wave) % 6], sub == 0);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// File: relative_strength_index.f
rtl/rsi_pkg.sv
rtl/rsi_queue.sv
rtl/rsi_front.sv
rtl/rsi_back.sv
rtl/relative_strength_index.sv
sim/rsi_checker.sv
sim/testbench.sv
